>>> rtl/core/hkrf_pkg.sv
`timescale 1ns / 1ps
// Package for the hue-keyed 3x3 rank filter: widths, register indexes,
// reset values and the control group that drives the window cells.
// No dependencies.
package hkrf_pkg;

   localparam int KEY_W              = 32;
   localparam int CHAN_W             = 8;
   localparam int COL_W              = 10;
   localparam int ROW_W              = 12;
   localparam int DIM_W              = 13;
   localparam int WIN_SIDE           = 3;
   localparam int WIN_N              = WIN_SIDE * WIN_SIDE;
   localparam int CNT_W              = 4;
   localparam int DEF_MAX_LINE_WIDTH = 1024;

   localparam int WIDTH_W = 11;
   localparam int HEIGHT_W = 13;
   localparam int RANK_W = 4;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANK_SELECT  = 2'd2;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [RANK_W-1:0]   RANK_RESET   = 4'd4;

   localparam logic [DIM_W-1:0]  DIM_MIN     = 13'd3;
   localparam logic [DIM_W-1:0]  HEIGHT_MAX  = 13'd4096;
   localparam logic [RANK_W-1:0] RANK_MAX    = 4'd8;

   typedef struct packed {
      logic shift;
      logic start;
      logic step;
   } cell_ctrl_type;

endpackage

>>> rtl/core/hue_keyed_rank_filter_3x3.sv
`timescale 1ns / 1ps
// Hue-keyed 3x3 rank filter, top level. Depends on hkrf_pkg, hkrf_ram,
// hkrf_hue and hkrf_cell.
// An accepted item passes through the hue divider, the window shift, the ring
// load, the circulation through the ring of cells and the emit step before it
// reaches the result register. A new item is accepted only when the block is
// back in idle after the emit step; a waiting result stalls the emit.
// Synchronous reset restores the register defaults and clears counters and
// window; the line stores are not cleared.
module hue_keyed_rank_filter_3x3 #(
   parameter int MAX_LINE_WIDTH = hkrf_pkg::DEF_MAX_LINE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [hkrf_pkg::CHAN_W-1:0]      req_red,
   input  logic [hkrf_pkg::CHAN_W-1:0]      req_green,
   input  logic [hkrf_pkg::CHAN_W-1:0]      req_blue,
   input  logic                             req_frame_start,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [hkrf_pkg::CHAN_W-1:0]      rsp_out_red,
   output logic [hkrf_pkg::CHAN_W-1:0]      rsp_out_green,
   output logic [hkrf_pkg::CHAN_W-1:0]      rsp_out_blue,
   output logic                             rsp_last_of_frame,
   input  logic                             csr_we,
   input  logic [hkrf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hkrf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hkrf_pkg::*;

   localparam int AW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
   localparam logic [DIM_W-1:0] MaxW = DIM_W'(MAX_LINE_WIDTH);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_HUE   = 6'b000010,
      S_SHIFT = 6'b000100,
      S_START = 6'b001000,
      S_RANK  = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [RANK_W-1:0]   rank_ff;
   logic [DIM_W-1:0]    w_eff, h_eff, col_ext, idx_ext;
   logic [RANK_W-1:0]   rank_eff;

   logic [COL_W-1:0]  col_ff, cur_col, item_col_ff;
   logic [ROW_W-1:0]  row_ff, cur_row, item_row_ff;
   logic [AW-1:0]     rd_addr, item_addr_ff;
   logic [CHAN_W-1:0] r_ff, g_ff, b_ff;
   logic              emit_ff, last_ff, line_end, frame_end;
   logic [CNT_W-1:0]  step_ff;

   logic              acc, hue_done, load_rsp;
   logic [CHAN_W-1:0] hue;
   logic [KEY_W-1:0]  new_key, above1, above2, sel_key;
   cell_ctrl_type     ctrl;

   logic [KEY_W-1:0]  key_out  [WIN_N];
   logic [KEY_W-1:0]  key_in   [WIN_N];
   logic [KEY_W-1:0]  circ_out [WIN_N];
   logic [WIN_N-1:0]  hit;

   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic              rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         rank_ff   <= RANK_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            CSR_RANK_SELECT:  rank_ff   <= csr_wdata[RANK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      w_eff = DIM_W'(width_ff);
      if (w_eff < DIM_MIN) w_eff = DIM_MIN;
      else if (w_eff > MaxW) w_eff = MaxW;
      h_eff = height_ff;
      if (h_eff < DIM_MIN) h_eff = DIM_MIN;
      else if (h_eff > HEIGHT_MAX) h_eff = HEIGHT_MAX;
      rank_eff = (rank_ff > RANK_MAX) ? RANK_MAX : rank_ff;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign acc       = req_valid && req_ready;
   assign cur_col   = req_frame_start ? '0 : col_ff;
   assign cur_row   = req_frame_start ? '0 : row_ff;
   assign col_ext   = DIM_W'(cur_col);
   assign idx_ext   = (col_ext > MaxW - 1'b1) ? (MaxW - 1'b1) : col_ext;
   assign rd_addr   = idx_ext[AW-1:0];

   assign line_end  = (DIM_W'(item_col_ff) + 1'b1) >= w_eff;
   assign frame_end = line_end && ((DIM_W'(item_row_ff) + 1'b1) >= h_eff);
   assign new_key   = {hue, r_ff, g_ff, b_ff};

   hkrf_hue u_hue (
      .clock (clock),
      .reset (reset),
      .start (acc),
      .red   (req_red),
      .green (req_green),
      .blue  (req_blue),
      .done  (hue_done),
      .hue   (hue)
   );

   hkrf_ram #(.WIDTH(KEY_W), .DEPTH(MAX_LINE_WIDTH)) u_line0 (
      .clock   (clock),
      .wr_en   (state_ff == S_SHIFT),
      .wr_addr (item_addr_ff),
      .wr_data (new_key),
      .rd_en   (acc),
      .rd_addr (rd_addr),
      .rd_data (above1)
   );

   hkrf_ram #(.WIDTH(KEY_W), .DEPTH(MAX_LINE_WIDTH)) u_line1 (
      .clock   (clock),
      .wr_en   (state_ff == S_SHIFT),
      .wr_addr (item_addr_ff),
      .wr_data (above1),
      .rd_en   (acc),
      .rd_addr (rd_addr),
      .rd_data (above2)
   );

   assign ctrl.shift = (state_ff == S_SHIFT);
   assign ctrl.start = (state_ff == S_START);
   assign ctrl.step  = (state_ff == S_RANK);

   for (genvar i = 0; i < WIN_N; i++) begin : g_cell
      localparam int Nxt = (i + 1) % WIN_N;
      if ((i % WIN_SIDE) != WIN_SIDE - 1) begin : g_mid
         assign key_in[i] = key_out[i + 1];
      end else if (i / WIN_SIDE == 0) begin : g_top
         assign key_in[i] = above2;
      end else if (i / WIN_SIDE == 1) begin : g_center
         assign key_in[i] = above1;
      end else begin : g_bottom
         assign key_in[i] = new_key;
      end
      hkrf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .rank     (rank_eff),
         .key_in   (key_in[i]),
         .key_out  (key_out[i]),
         .circ_in  (circ_out[Nxt]),
         .circ_out (circ_out[i]),
         .hit      (hit[i])
      );
   end

   always_comb begin
      sel_key = '0;
      for (int i = WIN_N - 1; i >= 0; i--) begin
         if (hit[i]) sel_key = key_out[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (acc) state_in = S_HUE;
         S_HUE:   if (hue_done) state_in = S_SHIFT;
         S_SHIFT: state_in = S_START;
         S_START: state_in = S_RANK;
         S_RANK:  if (step_ff == CNT_W'(WIN_N - 1)) state_in = S_EMIT;
         S_EMIT:  if (!emit_ff || !rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign load_rsp = (state_ff == S_EMIT) && emit_ff && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         step_ff      <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_SHIFT) begin
            emit_ff <= (item_col_ff >= COL_W'(2)) && (item_row_ff >= ROW_W'(2));
            if (line_end) begin
               col_ff <= '0;
               row_ff <= frame_end ? '0 : item_row_ff + 1'b1;
            end else begin
               col_ff <= item_col_ff + 1'b1;
               row_ff <= item_row_ff;
            end
         end
         if (state_ff == S_START) step_ff <= '0;
         else if (state_ff == S_RANK) step_ff <= step_ff + 1'b1;
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (acc) begin
         item_col_ff  <= cur_col;
         item_row_ff  <= cur_row;
         item_addr_ff <= rd_addr;
         r_ff         <= req_red;
         g_ff         <= req_green;
         b_ff         <= req_blue;
      end
      if (state_ff == S_SHIFT) last_ff <= frame_end;
      if (load_rsp) begin
         rsp_r_ff    <= sel_key[23:16];
         rsp_g_ff    <= sel_key[15:8];
         rsp_b_ff    <= sel_key[7:0];
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_red       = rsp_r_ff;
   assign rsp_out_green     = rsp_g_ff;
   assign rsp_out_blue      = rsp_b_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   a_hue_latency: assert property (@(posedge clock) disable iff (reset)
      acc |-> ##8 hue_done)
      else $error("hue divider did not finish in eight steps");

   a_rank_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && emit_ff) |-> (hit != '0))
      else $error("no window cell matched the selected rank");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT && emit_ff))
      else $error("result raised outside the emit step");

endmodule

>>> rtl/core/hkrf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hkrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/hkrf_hue.sv
`timescale 1ns / 1ps
// Hue unit: forms the hue numerator and divisor of one pixel and divides
// them with an eight-step restoring divider. Depends on hkrf_pkg.
module hkrf_hue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [hkrf_pkg::CHAN_W-1:0]  red,
   input  logic [hkrf_pkg::CHAN_W-1:0]  green,
   input  logic [hkrf_pkg::CHAN_W-1:0]  blue,
   output logic                         done,
   output logic [hkrf_pkg::CHAN_W-1:0]  hue
);
   import hkrf_pkg::*;

   logic [CHAN_W-1:0] mx, mn, d;
   logic [11:0]       dv, h6;
   logic [18:0]       num;

   logic              busy_ff, busy_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [18:0]       rem_ff, rem_in;
   logic [18:0]       dsh_ff, dsh_in;
   logic [CHAN_W-1:0] q_ff, q_in;
   logic              nz_ff, nz_in;

   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      d  = mx - mn;
      dv = 12'({d, 2'b00}) + 12'({d, 1'b0});
      if (blue == mx) begin
         h6 = 12'({d, 2'b00}) + 12'(red) - 12'(green);
      end else if (green == mx) begin
         h6 = 12'({d, 1'b0}) + 12'(blue) - 12'(red);
      end else if (green >= blue) begin
         h6 = 12'(green) - 12'(blue);
      end else begin
         h6 = dv + 12'(green) - 12'(blue);
      end
      num = 19'({h6, 8'b0}) - 19'(h6);
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      nz_in   = nz_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd7;
         rem_in  = num;
         dsh_in  = {dv, 7'b0};
         q_in    = '0;
         nz_in   = (d != '0);
      end else if (busy_ff) begin
         if (dsh_ff <= rem_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[CHAN_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[CHAN_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 3'd1;
         if (cnt_ff == 3'd0) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      nz_ff  <= nz_in;
   end

   assign done = busy_ff && (cnt_ff == 3'd0);
   assign hue  = nz_ff ? q_ff : '0;

endmodule

>>> rtl/core/hkrf_cell.sv
`timescale 1ns / 1ps
// One window cell: holds a key of the 3x3 window, passes it left on a shift,
// and counts smaller and equal keys as all keys circulate around the ring.
// Depends on hkrf_pkg.
module hkrf_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  hkrf_pkg::cell_ctrl_type       ctrl,
   input  logic [hkrf_pkg::RANK_W-1:0]   rank,
   input  logic [hkrf_pkg::KEY_W-1:0]    key_in,
   output logic [hkrf_pkg::KEY_W-1:0]    key_out,
   input  logic [hkrf_pkg::KEY_W-1:0]    circ_in,
   output logic [hkrf_pkg::KEY_W-1:0]    circ_out,
   output logic                          hit
);
   import hkrf_pkg::*;

   logic [KEY_W-1:0] key_ff, circ_ff;
   logic [CNT_W-1:0] lt_ff, eq_ff;
   logic [CNT_W:0]   upper;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (ctrl.shift) begin
         key_ff <= key_in;
      end
      if (ctrl.start) begin
         circ_ff <= key_ff;
         lt_ff   <= '0;
         eq_ff   <= '0;
      end else if (ctrl.step) begin
         circ_ff <= circ_in;
         if (circ_ff < key_ff) lt_ff <= lt_ff + 1'b1;
         if (circ_ff == key_ff) eq_ff <= eq_ff + 1'b1;
      end
   end

   assign upper    = {1'b0, lt_ff} + {1'b0, eq_ff};
   assign hit      = (lt_ff <= rank) && ({1'b0, rank} < upper);
   assign key_out  = key_ff;
   assign circ_out = circ_ff;

endmodule
